/* src/shfp_pkg.sv */
package shfp_pkg;

   localparam logic [15:0] SUM_START  = 16'hAAAA;
   localparam logic [31:0] SYNC_RESET = 32'hE4E5AB2D;

   typedef enum logic [1:0] {
      PH_HUNT,
      PH_HEADER,
      PH_PAYLOAD,
      PH_CHECK
   } phase_type;

   typedef enum logic [2:0] {
      OP_SYNC,
      OP_HEADER,
      OP_PAYLOAD,
      OP_CHECK_LO,
      OP_CHECK_HI
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [7:0]  data;
      logic [16:0] index;
      logic [15:0] seed;
   } token_type;

   typedef struct packed {
      logic        kind;
      logic [7:0]  data_byte;
      logic [16:0] byte_index;
      logic [15:0] msg_length;
      logic [31:0] seq_number;
      logic [15:0] msg_id;
      logic [15:0] msg_flags;
      logic [15:0] received_checksum;
      logic [15:0] computed_checksum;
      logic        last;
   } result_type;

   function automatic logic [15:0] fold_word(input logic [15:0] sum, input logic [15:0] word);
      logic [15:0] s;
      s = sum ^ word;
      return {s[14:0], s[15]};
   endfunction

endpackage

/* src/shfp_fifo.sv */
module shfp_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

/* src/shfp_front.sv */
module shfp_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  logic [7:0]          in_byte,
   input  logic [31:0]         sync_word,
   output logic                tok_push,
   output shfp_pkg::token_type tok
);
   import shfp_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [31:0] window_ff, window_in;
   logic [3:0]  count_ff, count_in;
   logic [15:0] length_ff, length_in;
   logic [16:0] pcount_ff, pcount_in;
   logic [31:0] win_shift;
   logic        pay_end;
   logic [15:0] seed;

   assign win_shift = {in_byte, window_ff[31:8]};
   assign pay_end   = ({1'b0, pcount_ff} + 18'd1) >= {1'b0, length_ff, 1'b0};
   assign seed      = fold_word(fold_word(SUM_START, win_shift[15:0]), win_shift[31:16]);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HUNT;
         window_ff <= '0;
         count_ff  <= '0;
         length_ff <= '0;
         pcount_ff <= '0;
      end else begin
         phase_ff  <= phase_in;
         window_ff <= window_in;
         count_ff  <= count_in;
         length_ff <= length_in;
         pcount_ff <= pcount_in;
      end
   end

   always_comb begin
      phase_in  = phase_ff;
      window_in = window_ff;
      count_in  = count_ff;
      length_in = length_ff;
      pcount_in = pcount_ff;
      tok_push  = 1'b0;
      tok.op    = OP_SYNC;
      tok.data  = in_byte;
      tok.index = '0;
      tok.seed  = seed;
      if (in_valid) begin
         unique case (phase_ff)
            PH_HUNT: begin
               window_in = win_shift;
               if (count_ff >= 4'd3 && win_shift == sync_word) begin
                  tok_push = 1'b1;
                  tok.op   = OP_SYNC;
                  count_in = '0;
                  phase_in = PH_HEADER;
               end else if (count_ff < 4'd3) begin
                  count_in = count_ff + 4'd1;
               end
            end
            PH_HEADER: begin
               tok_push  = 1'b1;
               tok.op    = OP_HEADER;
               tok.index = {13'd0, count_ff};
               if (count_ff == 4'd0) begin
                  length_in = {8'd0, in_byte};
               end else if (count_ff == 4'd1) begin
                  length_in = {in_byte, length_ff[7:0]};
               end
               if (count_ff >= 4'd9) begin
                  count_in  = '0;
                  pcount_in = '0;
                  phase_in  = (length_ff == '0) ? PH_CHECK : PH_PAYLOAD;
               end else begin
                  count_in = count_ff + 4'd1;
               end
            end
            PH_PAYLOAD: begin
               tok_push  = 1'b1;
               tok.op    = OP_PAYLOAD;
               tok.index = pcount_ff;
               if (pay_end) begin
                  count_in = '0;
                  phase_in = PH_CHECK;
               end else begin
                  pcount_in = pcount_ff + 17'd1;
               end
            end
            PH_CHECK: begin
               tok_push = 1'b1;
               if (count_ff == 4'd0) begin
                  tok.op   = OP_CHECK_LO;
                  count_in = 4'd1;
               end else begin
                  tok.op    = OP_CHECK_HI;
                  phase_in  = PH_HUNT;
                  window_in = '0;
                  count_in  = '0;
                  pcount_in = '0;
               end
            end
         endcase
      end
   end

endmodule

/* src/shfp_back.sv */
module shfp_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 tok_valid,
   input  shfp_pkg::token_type  tok,
   output logic                 res_valid,
   output shfp_pkg::result_type res
);
   import shfp_pkg::*;

   logic [15:0] sum_ff, sum_in;
   logic [7:0]  pend_ff, pend_in;
   logic [7:0]  cklo_ff, cklo_in;
   logic [15:0] length_ff, length_in;
   logic [31:0] seq_ff, seq_in;
   logic [15:0] id_ff, id_in;
   logic [15:0] flags_ff, flags_in;
   logic [15:0] folded;

   assign folded = fold_word(sum_ff, {tok.data, pend_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= SUM_START;
      end else begin
         sum_ff <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff   <= pend_in;
      cklo_ff   <= cklo_in;
      length_ff <= length_in;
      seq_ff    <= seq_in;
      id_ff     <= id_in;
      flags_ff  <= flags_in;
   end

   always_comb begin
      sum_in    = sum_ff;
      pend_in   = pend_ff;
      cklo_in   = cklo_ff;
      length_in = length_ff;
      seq_in    = seq_ff;
      id_in     = id_ff;
      flags_in  = flags_ff;
      res_valid = 1'b0;
      res.kind              = 1'b0;
      res.data_byte         = '0;
      res.byte_index        = '0;
      res.msg_length        = length_ff;
      res.seq_number        = seq_ff;
      res.msg_id            = id_ff;
      res.msg_flags         = flags_ff;
      res.received_checksum = '0;
      res.computed_checksum = '0;
      res.last              = 1'b0;
      if (tok_valid) begin
         unique case (tok.op)
            OP_SYNC: begin
               sum_in = tok.seed;
            end
            OP_HEADER: begin
               unique case (tok.index[3:0])
                  4'd0:    length_in = {8'd0, tok.data};
                  4'd1:    length_in = {tok.data, length_ff[7:0]};
                  4'd2:    seq_in = {24'd0, tok.data};
                  4'd3:    seq_in = {seq_ff[31:16], tok.data, seq_ff[7:0]};
                  4'd4:    seq_in = {seq_ff[31:24], tok.data, seq_ff[15:0]};
                  4'd5:    seq_in = {tok.data, seq_ff[23:0]};
                  4'd6:    id_in = {8'd0, tok.data};
                  4'd7:    id_in = {tok.data, id_ff[7:0]};
                  4'd8:    flags_in = {8'd0, tok.data};
                  default: flags_in = {tok.data, flags_ff[7:0]};
               endcase
               if (tok.index[0]) begin
                  sum_in = folded;
               end else begin
                  pend_in = tok.data;
               end
            end
            OP_PAYLOAD: begin
               res_valid      = 1'b1;
               res.data_byte  = tok.data;
               res.byte_index = tok.index;
               if (tok.index[0]) begin
                  sum_in = folded;
               end else begin
                  pend_in = tok.data;
               end
            end
            OP_CHECK_LO: begin
               cklo_in = tok.data;
            end
            OP_CHECK_HI: begin
               res_valid             = 1'b1;
               res.kind              = 1'b1;
               res.last              = 1'b1;
               res.received_checksum = {tok.data, cklo_ff};
               res.computed_checksum = sum_ff;
               sum_in                = SUM_START;
            end
            default: begin
               sum_in = sum_ff;
            end
         endcase
      end
   end

endmodule

/* src/sync_header_frame_parser_unit.sv */
// Byte-serial frame parser.
// Input queue side: drive req_in_byte and push; a byte is taken on a clock edge
// with push high and full low. Configuration: csr_write_enable/csr_write_data
// load the 32-bit sync word (first received byte is its low byte); write only
// while idle. Result queue side: while empty is low the oldest result sits on
// the rsp_ ports; pop high with empty low takes it.
// Each sync hit, header and payload byte, and checksum byte becomes a
// transaction in a small internal queue; the back end turns it into at most one
// result. A payload byte or the second checksum byte goes through the internal
// queue and then the result queue to reach the rsp_ ports. One byte per cycle
// is sustained as long as results are popped; a stalled result side fills the
// result queue, then the internal queue, and then raises full.
// Reset: sync word returns to 0xE4E5AB2D, parser hunts for sync, both queues
// empty. Reset is synchronous, active high.
module sync_header_frame_parser_unit #(
   parameter int MID_DEPTH = 4,
   parameter int OUT_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  logic [7:0]  req_in_byte,
   output logic        full,
   input  logic        csr_write_enable,
   input  logic [31:0] csr_write_data,
   output logic        empty,
   input  logic        pop,
   output logic        rsp_kind,
   output logic [7:0]  rsp_data_byte,
   output logic [16:0] rsp_byte_index,
   output logic [15:0] rsp_msg_length,
   output logic [31:0] rsp_seq_number,
   output logic [15:0] rsp_msg_id,
   output logic [15:0] rsp_msg_flags,
   output logic [15:0] rsp_received_checksum,
   output logic [15:0] rsp_computed_checksum,
   output logic        rsp_last
);
   import shfp_pkg::*;

   localparam int TOK_W = $bits(token_type);
   localparam int RES_W = $bits(result_type);

   logic [31:0]      sync_word_ff;
   logic             in_valid;
   logic             tok_push;
   token_type        tok_front;
   logic [TOK_W-1:0] tok_rdata;
   token_type        tok_back;
   logic             mid_full, mid_empty, mid_pop;
   logic             res_valid;
   result_type       res_back;
   logic [RES_W-1:0] res_rdata;
   result_type       res_out;
   logic             out_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_word_ff <= SYNC_RESET;
      end else if (csr_write_enable) begin
         sync_word_ff <= csr_write_data;
      end
   end

   assign full     = mid_full;
   assign in_valid = push && !mid_full;
   assign mid_pop  = !mid_empty && !out_full;
   assign tok_back = token_type'(tok_rdata);
   assign res_out  = result_type'(res_rdata);

   shfp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (in_valid),
      .in_byte   (req_in_byte),
      .sync_word (sync_word_ff),
      .tok_push  (tok_push),
      .tok       (tok_front)
   );

   shfp_fifo #(.WIDTH(TOK_W), .DEPTH(MID_DEPTH)) u_mid_queue (
      .clock (clock),
      .reset (reset),
      .push  (tok_push),
      .wdata (tok_front),
      .full  (mid_full),
      .pop   (mid_pop),
      .rdata (tok_rdata),
      .empty (mid_empty)
   );

   shfp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .tok_valid (mid_pop),
      .tok       (tok_back),
      .res_valid (res_valid),
      .res       (res_back)
   );

   shfp_fifo #(.WIDTH(RES_W), .DEPTH(OUT_DEPTH)) u_out_queue (
      .clock (clock),
      .reset (reset),
      .push  (res_valid),
      .wdata (res_back),
      .full  (out_full),
      .pop   (pop),
      .rdata (res_rdata),
      .empty (empty)
   );

   assign rsp_kind              = res_out.kind;
   assign rsp_data_byte         = res_out.data_byte;
   assign rsp_byte_index        = res_out.byte_index;
   assign rsp_msg_length        = res_out.msg_length;
   assign rsp_seq_number        = res_out.seq_number;
   assign rsp_msg_id            = res_out.msg_id;
   assign rsp_msg_flags         = res_out.msg_flags;
   assign rsp_received_checksum = res_out.received_checksum;
   assign rsp_computed_checksum = res_out.computed_checksum;
   assign rsp_last              = res_out.last;

   a_no_res_overflow: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> !out_full)
      else $error("result written into full queue");

   a_no_tok_overflow: assert property (@(posedge clock) disable iff (reset)
      tok_push |-> !mid_full)
      else $error("transaction written into full queue");

   a_end_record_clean: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_kind) |-> (rsp_data_byte == '0 && rsp_byte_index == '0 && rsp_last))
      else $error("end record carries payload fields");

endmodule
